/* rtl/core/gmwf_pkg.sv */
// package for the gated five-entry median window filter
// holds the sample type, window sizing constants and the window bundle
// no dependencies
package gmwf_pkg;

    localparam int WindowLen = 5;
    localparam int SampleW   = 16;
    localparam int IdxW      = $clog2(WindowLen);
    localparam int RankW     = $clog2(WindowLen);
    localparam int MidRank   = WindowLen / 2;

    typedef logic signed [SampleW-1:0] t_sample;

    // window entries handed from the cell chain to the median network
    typedef struct packed {
        t_sample [WindowLen-1:0] entry;
    } t_window;

endpackage

/* rtl/core/gmwf_cell.sv */
// one window cell: holds one stored sample and hands it to its neighbor on a shift
// depends on gmwf_pkg
module gmwf_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  gmwf_pkg::t_sample i_prev,
    output gmwf_pkg::t_sample o_val,
    output gmwf_pkg::t_sample o_next
);

    gmwf_pkg::t_sample r_val;
    gmwf_pkg::t_sample n_val;

    // take the neighbor's value when the chain advances
    always_comb begin
        n_val = i_shift ? i_prev : r_val;
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule

/* rtl/core/gmwf_median.sv */
// rank-select median network over the window entries
// depends on gmwf_pkg
module gmwf_median (
    input  gmwf_pkg::t_window i_win,
    output gmwf_pkg::t_sample o_median
);

    logic [gmwf_pkg::RankW-1:0] rank [gmwf_pkg::WindowLen];

    // rank each entry, ties broken by position so exactly one entry has the middle rank
    always_comb begin
        for (int i = 0; i < gmwf_pkg::WindowLen; i++) begin
            rank[i] = '0;
            for (int j = 0; j < gmwf_pkg::WindowLen; j++) begin
                if ((i_win.entry[j] < i_win.entry[i]) ||
                    ((i_win.entry[j] == i_win.entry[i]) && (j < i))) begin
                    rank[i] = rank[i] + gmwf_pkg::RankW'(1);
                end
            end
        end
    end

    // pick the entry whose rank is the middle one
    always_comb begin
        o_median = '0;
        for (int i = 0; i < gmwf_pkg::WindowLen; i++) begin
            if (rank[i] == gmwf_pkg::RankW'(gmwf_pkg::MidRank)) begin
                o_median = o_median | i_win.entry[i];
            end
        end
    end

endmodule

/* rtl/core/gated_median5_window_filter.sv */
// top level of the gated five-entry median window filter
// depends on gmwf_pkg, gmwf_cell and gmwf_median
//
// Each transaction carries one signed 16-bit sample. Samples greater than zero
// enter a chain of five cells; zero and negative samples leave the window as is.
// Until five positive samples have been stored the sample is returned unchanged
// with o_window_full low; from then on every transaction returns the median of
// the five stored samples with o_window_full high, including the transaction that
// stores the fifth sample. One transaction is taken every clock cycle while o_stall
// is low; its result is registered in the output register, or first in the skid
// register while the output register is held. The two registers let input keep
// flowing while a result waits; o_stall rises only when both are occupied.
module gated_median5_window_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [15:0] i_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_filtered,
    output logic        o_window_full
);

    localparam int Len  = gmwf_pkg::WindowLen;
    localparam int IdxW = gmwf_pkg::IdxW;

    logic                accept;
    logic                shift;
    logic                out_take;
    logic                res_full;
    gmwf_pkg::t_sample   res_filt;
    gmwf_pkg::t_sample   median;
    gmwf_pkg::t_window   win_next;
    gmwf_pkg::t_sample   cell_val [Len];

    logic [IdxW-1:0]     r_widx;
    logic [IdxW-1:0]     n_widx;
    logic                r_filled;
    logic                n_filled;

    logic                r_out_valid;
    logic                r_out_full;
    gmwf_pkg::t_sample   r_out_filt;
    logic                r_skid_valid;
    logic                r_skid_full;
    gmwf_pkg::t_sample   r_skid_filt;

    // input handshake and store gate
    assign accept = i_valid && !o_stall;
    assign shift  = accept && !i_sample[15] && (|i_sample);

    // chain of window cells, cell zero takes the new sample
    for (genvar k = 0; k < Len; k++) begin : g_cell
        gmwf_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(shift),
            .i_prev ((k == 0) ? gmwf_pkg::t_sample'(i_sample) : cell_val[(k == 0) ? 0 : k-1]),
            .o_val  (cell_val[k]),
            .o_next (win_next.entry[k])
        );
    end

    // median of the window as it stands after this transaction
    gmwf_median u_median (
        .i_win   (win_next),
        .o_median(median)
    );

    // write position and filled flag
    always_comb begin
        n_widx   = r_widx;
        n_filled = r_filled;
        if (shift) begin
            if (r_widx == IdxW'(Len - 1)) begin
                n_widx   = '0;
                n_filled = 1'b1;
            end else begin
                n_widx = r_widx + IdxW'(1);
            end
        end
    end

    assign res_full = n_filled;
    assign res_filt = n_filled ? median : gmwf_pkg::t_sample'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx   <= '0;
            r_filled <= 1'b0;
        end else begin
            r_widx   <= n_widx;
            r_filled <= n_filled;
        end
    end

    // output register with skid stage
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_filt <= r_skid_filt;
                r_out_full <= r_skid_full;
            end else begin
                r_out_filt <= res_filt;
                r_out_full <= res_full;
            end
        end else if (accept) begin
            r_skid_filt <= res_filt;
            r_skid_full <= res_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_filtered    = r_out_filt;
    assign o_window_full = r_out_full;

endmodule
